FILE: sv/lmrs_pkg.sv
package lmrs_pkg;

    // display geometry, which fits within the widths of the item fields
    localparam int ROWS        = 18;
    localparam int COLUMN_REGS = 7;
    localparam int FRAMES      = 4;
    localparam int SHIFTS      = 8;

    // field widths
    localparam int CMD_W   = 2;
    localparam int FRAME_W = 2;
    localparam int ROW_W   = 5;
    localparam int REG_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 3;
    localparam int SHIFT_W = $clog2(SHIFTS);

    // frame store: one row of bytes per address, one ram per column register
    localparam int STORE_ROWS = FRAMES * ROWS;
    localparam int ADDR_W     = $clog2(STORE_ROWS);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // frames in use after reset
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 3'd3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd2;

    typedef enum logic {
        OP_WRITE,
        OP_STEP
    } op_kind_t;

    // one queued operation for the back end
    typedef struct packed {
        op_kind_t           kind;
        logic [FRAME_W-1:0] frame;
        logic [ROW_W-1:0]   row;
        logic [REG_W-1:0]   reg_sel;
        logic [BYTE_W-1:0]  data;
        logic               serial;
    } op_t;

    // frame and row to store address
    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [FRAME_W-1:0] frame,
        input logic [ROW_W-1:0]   row
    );
        return ADDR_W'(frame) * ADDR_W'(ROWS) + ADDR_W'(row);
    endfunction

endpackage

FILE: sv/led_matrix_row_scanner_core.sv
// LED matrix row scanner for displays built from chained shift registers.
// Input channel (in_valid/in_ready) takes one command item per cycle unless full:
// write one stored frame byte, step the scan row, or advance the frame.
// Output channel (out_valid/out_ready) gives eight shift items per row step,
// bit 0 of each column byte first; the eighth carries latch.
// A row step goes from the queue head through the store read into the fetch
// stage, then into the shifter once the queue ahead of it is empty and the
// shifter is free; its eight items leave one per cycle while out_ready is high.
// The next row is fetched during shifting, so the row shifter bounds steps.
// Writes use one queue slot and reach the store at the edge after they reach
// the queue head; frame advances act in the decoder and use no queue slot.
// A 4-deep queue sits between the command decoder and the store/shifter,
// so items keep being taken while the receiver stalls; in_ready drops only
// when the queue is full. Results hold steady while out_ready is low.
// cfg_we writes frames_in_use (reset 3); write it only while idle.
// Reset puts the scan on row 0, frame 0, no frame change pending.
// Frame contents are undefined after reset: load a frame before showing it.
module led_matrix_row_scanner_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lmrs_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lmrs_pkg::CMD_W-1:0]          command,
    input  logic [lmrs_pkg::FRAME_W-1:0]        frame_sel,
    input  logic [lmrs_pkg::ROW_W-1:0]          row_sel,
    input  logic [lmrs_pkg::REG_W-1:0]          reg_sel,
    input  logic [lmrs_pkg::BYTE_W-1:0]         byte_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lmrs_pkg::COLUMN_REGS-1:0]    column_bits,
    output logic                                row_serial,
    output logic [lmrs_pkg::ROW_W-1:0]          shown_row,
    output logic [lmrs_pkg::FRAME_W-1:0]        shown_frame,
    output logic                                latch
);
    import lmrs_pkg::*;

    logic accept;
    logic push;
    op_t  push_op;
    op_t  head_op;
    logic head_valid;
    logic pop;
    logic queue_full;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // command decode and scan state
    lmrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .command    (command),
        .frame_sel  (frame_sel),
        .row_sel    (row_sel),
        .reg_sel    (reg_sel),
        .byte_value (byte_value),
        .push       (push),
        .op         (push_op)
    );

    // op queue between decode and execution
    lmrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .head_op   (head_op),
        .not_empty (head_valid),
        .full      (queue_full)
    );

    // frame store and row shifter
    lmrs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_op     (head_op),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .column_bits (column_bits),
        .row_serial  (row_serial),
        .shown_row   (shown_row),
        .shown_frame (shown_frame),
        .latch       (latch)
    );

endmodule

FILE: sv/lmrs_ram.sv
module lmrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 72
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/lmrs_front.sv
module lmrs_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lmrs_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           accept,
    input  logic [lmrs_pkg::CMD_W-1:0]     command,
    input  logic [lmrs_pkg::FRAME_W-1:0]   frame_sel,
    input  logic [lmrs_pkg::ROW_W-1:0]     row_sel,
    input  logic [lmrs_pkg::REG_W-1:0]     reg_sel,
    input  logic [lmrs_pkg::BYTE_W-1:0]    byte_value,
    output logic                           push,
    output lmrs_pkg::op_t                  op
);
    import lmrs_pkg::*;

    logic [CFG_W-1:0]   frames_in_use_reg;
    logic [ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [FRAME_W-1:0] displayed_reg, displayed_next;
    logic [FRAME_W-1:0] selected_reg, selected_next;
    logic               swap_pending_reg, swap_pending_next;
    logic [CFG_W-1:0]   frame_limit;
    logic [FRAME_W:0]   selected_plus;

    // clamp frames in use to 1..FRAMES
    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            frame_limit = CFG_W'(1);
        end
        else if (frames_in_use_reg > CFG_W'(FRAMES))
        begin
            frame_limit = CFG_W'(FRAMES);
        end
        else
        begin
            frame_limit = frames_in_use_reg;
        end
    end

    assign selected_plus = {1'b0, selected_reg} + (FRAME_W+1)'(1);

    // classify the item, update scan state, build the queued op
    always_comb
    begin
        scan_row_next     = scan_row_reg;
        displayed_next    = displayed_reg;
        selected_next     = selected_reg;
        swap_pending_next = swap_pending_reg;
        push              = 1'b0;
        op.kind           = OP_WRITE;
        op.frame          = frame_sel;
        op.row            = row_sel;
        op.reg_sel        = reg_sel;
        op.data           = byte_value;
        op.serial         = 1'b0;
        if (accept)
        begin
            unique case (command)
                CMD_WRITE:
                begin
                    push = ({1'b0, frame_sel} < (FRAME_W+1)'(FRAMES)) &&
                           (row_sel < ROW_W'(ROWS)) &&
                           (reg_sel < REG_W'(COLUMN_REGS));
                end
                CMD_BUTTON:
                begin
                    if (selected_plus < (FRAME_W+1)'(frame_limit))
                    begin
                        selected_next = selected_plus[FRAME_W-1:0];
                    end
                    else
                    begin
                        selected_next = '0;
                    end
                    swap_pending_next = 1'b1;
                end
                CMD_STEP:
                begin
                    if (scan_row_reg >= ROW_W'(ROWS - 1))
                    begin
                        scan_row_next = '0;
                        op.serial     = 1'b1;
                        if (swap_pending_reg)
                        begin
                            displayed_next    = selected_reg;
                            swap_pending_next = 1'b0;
                        end
                    end
                    else
                    begin
                        scan_row_next = scan_row_reg + ROW_W'(1);
                    end
                    push     = 1'b1;
                    op.kind  = OP_STEP;
                    op.row   = scan_row_next;
                    op.frame = displayed_next;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // scan state and configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
            scan_row_reg      <= '0;
            displayed_reg     <= '0;
            selected_reg      <= '0;
            swap_pending_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frames_in_use_reg <= cfg_wdata;
            end
            scan_row_reg     <= scan_row_next;
            displayed_reg    <= displayed_next;
            selected_reg     <= selected_next;
            swap_pending_reg <= swap_pending_next;
        end
    end

endmodule

FILE: sv/lmrs_queue.sv
module lmrs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lmrs_pkg::op_t push_op,
    input  logic          pop,
    output lmrs_pkg::op_t head_op,
    output logic          not_empty,
    output logic          full
);
    import lmrs_pkg::*;

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_op   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: sv/lmrs_back.sv
module lmrs_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lmrs_pkg::op_t                       head_op,
    input  logic                                head_valid,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lmrs_pkg::COLUMN_REGS-1:0]    column_bits,
    output logic                                row_serial,
    output logic [lmrs_pkg::ROW_W-1:0]          shown_row,
    output logic [lmrs_pkg::FRAME_W-1:0]        shown_frame,
    output logic                                latch
);
    import lmrs_pkg::*;

    logic [ADDR_W-1:0]  op_addr;
    logic               ram_re;
    logic [BYTE_W-1:0]  ram_rdata [COLUMN_REGS];

    logic               fetch_valid_reg, fetch_valid_next;
    logic [ROW_W-1:0]   fetch_row_reg;
    logic [FRAME_W-1:0] fetch_frame_reg;
    logic               fetch_serial_reg;
    logic               fetch_free;

    logic               shift_valid_reg, shift_valid_next;
    logic [SHIFT_W-1:0] shift_cnt_reg, shift_cnt_next;
    logic [BYTE_W-1:0]  shift_bytes_reg [COLUMN_REGS];
    logic [ROW_W-1:0]   shift_row_reg;
    logic [FRAME_W-1:0] shift_frame_reg;
    logic               shift_serial_reg;
    logic               shift_fire;
    logic               shift_done;
    logic               shift_load;

    // handshake between queue, fetch stage and shifter
    assign shift_fire = shift_valid_reg && out_ready;
    assign shift_done = shift_fire && (shift_cnt_reg == SHIFT_W'(SHIFTS - 1));
    assign shift_load = fetch_valid_reg && (!shift_valid_reg || shift_done);
    assign fetch_free = !fetch_valid_reg || shift_load;
    assign pop        = head_valid && ((head_op.kind == OP_WRITE) || fetch_free);
    assign ram_re     = pop && (head_op.kind == OP_STEP);
    assign op_addr    = store_addr(head_op.frame, head_op.row);

    // one ram per column register, all read at the same row
    for (genvar k = 0; k < COLUMN_REGS; k++)
    begin : g_col
        lmrs_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (STORE_ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (pop && (head_op.kind == OP_WRITE) &&
                    (head_op.reg_sel == REG_W'(k))),
            .waddr (op_addr),
            .wdata (head_op.data),
            .re    (ram_re),
            .raddr (op_addr),
            .rdata (ram_rdata[k])
        );
    end

    // fetch stage control
    always_comb
    begin
        fetch_valid_next = fetch_valid_reg;
        if (ram_re)
        begin
            fetch_valid_next = 1'b1;
        end
        else if (shift_load)
        begin
            fetch_valid_next = 1'b0;
        end
    end

    // shifter control
    always_comb
    begin
        shift_valid_next = shift_valid_reg;
        shift_cnt_next   = shift_cnt_reg;
        if (shift_load)
        begin
            shift_valid_next = 1'b1;
            shift_cnt_next   = '0;
        end
        else if (shift_done)
        begin
            shift_valid_next = 1'b0;
        end
        else if (shift_fire)
        begin
            shift_cnt_next = shift_cnt_reg + SHIFT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_valid_reg <= 1'b0;
            shift_valid_reg <= 1'b0;
            shift_cnt_reg   <= '0;
        end
        else
        begin
            fetch_valid_reg <= fetch_valid_next;
            shift_valid_reg <= shift_valid_next;
            shift_cnt_reg   <= shift_cnt_next;
        end
    end

    // fetch and shifter payload
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            fetch_row_reg    <= head_op.row;
            fetch_frame_reg  <= head_op.frame;
            fetch_serial_reg <= head_op.serial;
        end
        if (shift_load)
        begin
            shift_bytes_reg  <= ram_rdata;
            shift_row_reg    <= fetch_row_reg;
            shift_frame_reg  <= fetch_frame_reg;
            shift_serial_reg <= fetch_serial_reg;
        end
    end

    // result: bit b of every column byte
    for (genvar k = 0; k < COLUMN_REGS; k++)
    begin : g_bit
        assign column_bits[k] = shift_bytes_reg[k][shift_cnt_reg];
    end

    assign out_valid   = shift_valid_reg;
    assign row_serial  = shift_serial_reg;
    assign shown_row   = shift_row_reg;
    assign shown_frame = shift_frame_reg;
    assign latch       = (shift_cnt_reg == SHIFT_W'(SHIFTS - 1));

endmodule
